[hw/rtl/uer_pkg.sv]
// Package for the ultrasonic echo ranger: phase and sequencer codes,
// configuration register indexes and arithmetic constants.
// No dependencies.
package uer_pkg;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_TEMPERATURE = 2'd0;
	localparam cfg_idx_t CFG_TICKS_PER_MS = 2'd1;
	localparam cfg_idx_t CFG_TRIGGER_TICKS = 2'd2;
	localparam cfg_idx_t CFG_TIMEOUT_TICKS = 2'd3;

	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]  TEMPERATURE_RST = 8'd22;
	localparam logic [15:0] TICKS_PER_MS_RST = 16'd1000;
	localparam logic [9:0]  TRIGGER_TICKS_RST = 10'd10;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'hFFFF;

	// Speed of sound in dm/s: base + slope*T, less a humidity share per 100
	localparam int AIR_BASE = 3313;
	localparam int AIR_SLOPE = 6;
	localparam int HUMID_LOSS = 17;
	localparam int AIR_W = 13;
	// floor(a/100) == (a*RECIP_100) >> RECIP_SHIFT for all a below 8192
	localparam int RECIP_100 = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_PROD_W = 26;

	localparam int US_PER_MS = 1000;
	localparam int DIST_SCALE = 100;
	localparam int US_W = 16;
	localparam int DIST_W = 11;
	localparam int US100_W = 23;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_TRIGGER = 4'b0010,
		PH_ARMED   = 4'b0100,
		PH_MEASURE = 4'b1000
	} phase_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_USLD = 6'b000010,
		S_DIV  = 6'b000100,
		S_AIR1 = 6'b001000,
		S_AIR2 = 6'b010000,
		S_OUT  = 6'b100000
	} seq_t;

endpackage

[hw/rtl/uer_if.sv]
// Handshake channels of the ultrasonic echo ranger: tick input, result
// output and configuration write. Depends on uer_pkg.
interface uer_tick_if;
	logic valid;
	logic ready;
	logic cmd;
	logic echo_level;
	modport source(output valid, output cmd, output echo_level, input ready);
	modport sink(input valid, input cmd, input echo_level, output ready);
endinterface

interface uer_result_if;
	logic        valid;
	logic        ready;
	logic        trigger_out;
	logic        busy_res;
	logic        done_res;
	logic        timed_out;
	logic [15:0] echo_us;
	logic [10:0] distance_cm;
	modport source(output valid, output trigger_out, output busy_res, output done_res,
		output timed_out, output echo_us, output distance_cm, input ready);
	modport sink(input valid, input trigger_out, input busy_res, input done_res,
		input timed_out, input echo_us, input distance_cm, output ready);
endinterface

interface uer_cfg_if;
	logic                 valid;
	logic                 ready;
	uer_pkg::cfg_idx_t    index;
	logic [15:0]          data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[hw/rtl/ultrasonic_echo_ranger_top.sv]
// Ultrasonic echo ranger: trigger/echo timing, tick-to-microsecond
// conversion and distance, on a shared bit-serial divider.
// Depends on uer_pkg and the channels in uer_if.sv.
//
//   channel  dir  payload                                          handshake
//   tick     in   cmd, echo_level                                  valid/ready
//   result   out  trigger_out busy_res done_res timed_out          valid/ready
//                 echo_us distance_cm
//   cfg      in   index (2b), data (16b)                           valid/ready
//
// One item at a time: a tick runs the distance division before its result is
// valid; a tick that ends with an echo falling edge first runs the us division.
// Both use the restoring divider, one quotient bit per cycle.
// The next tick is taken once the result is in the output register, even if
// it is not yet taken. Reset is asynchronous; cfg is always ready.
module ultrasonic_echo_ranger_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	uer_tick_if.sink       tick,
	uer_result_if.source   result,
	uer_cfg_if.sink        cfg
);
	import uer_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int PW = CW + 10;                      // count*1000 width
	localparam int DIV_W = (PW > US100_W) ? PW : US100_W;
	localparam int CNTW = $clog2(DIV_W + 1);
	localparam int CMPW = (CW > 16) ? CW : 16;

	// Configuration
	logic [7:0]  temperature_q;
	logic [15:0] ticks_per_ms_q;
	logic [9:0]  trigger_ticks_q;
	logic [15:0] timeout_ticks_q;

	// Ranger state
	phase_t         phase_q;
	logic [CW-1:0]  tick_q;
	logic [9:0]     pulse_q;
	logic           prev_echo_q;
	logic [15:0]    last_good_us_q;

	// Sequencer and work registers
	seq_t              state_q;
	logic              w_trig_q, w_busy_q, w_done_q, w_tmo_q, w_capture_q;
	logic [15:0]       w_us_q;

	logic [DIV_W-1:0]  dvd_q;
	logic [15:0]       rem_q;
	logic [15:0]       dsr_q;
	logic [15:0]       quo_q;
	logic              sat_q;
	logic [CNTW-1:0]   div_cnt_q;
	logic              div_dist_q;

	logic [AIR_W-1:0]  air_base_q;
	logic [5:0]        hund_q;

	// Output register
	logic              res_valid_q;
	logic              res_trig_q, res_busy_q, res_done_q, res_tmo_q;
	logic [15:0]       res_us_q;
	logic [10:0]       res_dist_q;

	// ---------------- per-tick phase logic ----------------
	phase_t        nx_phase;
	logic [CW-1:0] nx_tick, cnt_inc;
	logic [9:0]    nx_pulse;
	logic          a_trig, a_done, a_tmo, a_capture;
	logic          rise, fall, timeout_hit;
	logic          tick_acc;

	assign tick_acc = tick.valid && tick.ready;
	assign rise = tick.echo_level && !prev_echo_q;
	assign fall = !tick.echo_level && prev_echo_q;
	assign cnt_inc = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
	assign timeout_hit = (CMPW'(cnt_inc) >= CMPW'(timeout_ticks_q)) || (cnt_inc == '1);

	always_comb begin
		nx_phase = phase_q;
		nx_tick = tick_q;
		nx_pulse = pulse_q;
		a_trig = 1'b0;
		a_done = 1'b0;
		a_tmo = 1'b0;
		a_capture = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (tick.cmd) begin
					nx_phase = PH_TRIGGER;
					nx_pulse = 10'd1;
					a_trig = 1'b1;
				end
			end
			PH_TRIGGER: begin
				if (pulse_q < trigger_ticks_q) begin
					nx_pulse = pulse_q + 10'd1;
					a_trig = 1'b1;
				end else begin
					nx_phase = PH_ARMED;
					nx_tick = '0;
				end
			end
			PH_ARMED, PH_MEASURE: begin
				nx_tick = cnt_inc;
				if (phase_q == PH_ARMED && rise) begin
					nx_tick = '0;
					nx_phase = PH_MEASURE;
				end else if (phase_q == PH_MEASURE && fall) begin
					a_capture = 1'b1;
					a_done = 1'b1;
					nx_phase = PH_IDLE;
				end else if (timeout_hit) begin
					a_done = 1'b1;
					a_tmo = 1'b1;
					nx_phase = PH_IDLE;
				end
			end
			default: begin
				nx_phase = PH_IDLE;
			end
		endcase
	end

	// ---------------- divider step ----------------
	logic [16:0]  r_sh, r_diff;
	logic         q_bit;
	logic [15:0]  rem_nx, quo_nx;
	logic         sat_nx;
	logic [15:0]  us_final;

	assign r_sh = {rem_q, dvd_q[DIV_W-1]};
	assign r_diff = r_sh - {1'b0, dsr_q};
	assign q_bit = (r_sh >= {1'b0, dsr_q});
	assign rem_nx = q_bit ? r_diff[15:0] : r_sh[15:0];
	assign quo_nx = {quo_q[14:0], q_bit};
	assign sat_nx = sat_q | quo_q[15];
	assign us_final = sat_nx ? 16'hFFFF : quo_nx;

	// ---------------- operand preparation ----------------
	logic [PW-1:0]           us_prod;
	logic [US100_W-1:0]      us100;
	logic [AIR_W-1:0]        air_base, airspeed;
	logic [RECIP_PROD_W-1:0] recip_prod;

	assign us_prod = PW'(tick_q) * PW'(US_PER_MS);
	assign us100 = US100_W'(last_good_us_q) * US100_W'(DIST_SCALE);
	assign air_base = AIR_W'(AIR_BASE) + AIR_W'(temperature_q) * AIR_W'(AIR_SLOPE);
	assign recip_prod = RECIP_PROD_W'(air_base) * RECIP_PROD_W'(RECIP_100);
	assign airspeed = air_base_q - AIR_W'(hund_q) * AIR_W'(HUMID_LOSS);

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!res_valid_q || result.ready);

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temperature_q <= TEMPERATURE_RST;
			ticks_per_ms_q <= TICKS_PER_MS_RST;
			trigger_ticks_q <= TRIGGER_TICKS_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TEMPERATURE: temperature_q <= cfg.data[7:0];
				CFG_TICKS_PER_MS: ticks_per_ms_q <= cfg.data;
				CFG_TRIGGER_TICKS: trigger_ticks_q <= cfg.data[9:0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			tick_q <= '0;
			pulse_q <= '0;
			prev_echo_q <= 1'b0;
			last_good_us_q <= '0;
			res_valid_q <= 1'b0;
			div_cnt_q <= '0;
			div_dist_q <= 1'b0;
		end else begin
			if (out_load)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (tick_acc) begin
						phase_q <= nx_phase;
						tick_q <= nx_tick;
						pulse_q <= nx_pulse;
						prev_echo_q <= tick.echo_level;
						state_q <= a_capture ? S_USLD : S_AIR1;
					end
				end
				S_USLD: begin
					div_cnt_q <= CNTW'(PW);
					div_dist_q <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == CNTW'(1)) begin
						if (div_dist_q) begin
							state_q <= S_OUT;
						end else begin
							last_good_us_q <= us_final;
							state_q <= S_AIR1;
						end
					end
				end
				S_AIR1: begin
					state_q <= S_AIR2;
				end
				S_AIR2: begin
					div_cnt_q <= CNTW'(US100_W);
					div_dist_q <= 1'b1;
					state_q <= S_DIV;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (tick_acc) begin
					w_trig_q <= a_trig;
					w_busy_q <= (nx_phase != PH_IDLE);
					w_done_q <= a_done;
					w_tmo_q <= a_tmo;
					w_capture_q <= a_capture;
					w_us_q <= '0;
				end
			end
			S_USLD: begin
				// dividend enters MSB first, left aligned in the shift register
				dvd_q <= DIV_W'(us_prod) << (DIV_W - PW);
				rem_q <= '0;
				quo_q <= '0;
				sat_q <= 1'b0;
				dsr_q <= (ticks_per_ms_q == '0) ? 16'd1 : ticks_per_ms_q;
			end
			S_DIV: begin
				dvd_q <= dvd_q << 1;
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				sat_q <= sat_nx;
				if (div_cnt_q == CNTW'(1) && !div_dist_q)
					w_us_q <= us_final;
			end
			S_AIR1: begin
				air_base_q <= air_base;
				hund_q <= recip_prod[RECIP_SHIFT+5:RECIP_SHIFT];
			end
			S_AIR2: begin
				// (us*100)/a/2 == (us*100)/(2a)
				dvd_q <= DIV_W'(us100) << (DIV_W - US100_W);
				rem_q <= '0;
				quo_q <= '0;
				sat_q <= 1'b0;
				dsr_q <= 16'({airspeed, 1'b0});
			end
			S_OUT: begin
				if (out_load) begin
					res_trig_q <= w_trig_q;
					res_busy_q <= w_busy_q;
					res_done_q <= w_done_q;
					res_tmo_q <= w_tmo_q;
					res_us_q <= w_capture_q ? w_us_q : 16'd0;
					res_dist_q <= quo_q[10:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign tick.ready = (state_q == S_IDLE);
	assign result.valid = res_valid_q;
	assign result.trigger_out = res_trig_q;
	assign result.busy_res = res_busy_q;
	assign result.done_res = res_done_q;
	assign result.timed_out = res_tmo_q;
	assign result.echo_us = res_us_q;
	assign result.distance_cm = res_dist_q;

	// ---------------- assertions ----------------
	a_div_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_cnt_q != '0)
		else $error("divider running with zero step count");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after tick accept");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_dist_q <= 11'd1190)
		else $error("distance out of range");

	a_timeout_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_tmo_q |-> res_done_q && res_us_q == 16'd0)
		else $error("timeout result without done or with nonzero time");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && res_valid_q && !result.ready |=> state_q == S_OUT)
		else $error("finished item left S_OUT while output register full");

endmodule
